FILE: src/eaq_pkg.sv
// ----------------------------------------------------------------------------
// Euler angles to quaternion: shared constants and types
// Field widths, fixed-point formats, and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package eaq_pkg;

  localparam int ANGLE_W       = 16;
  localparam int QUAT_W        = 16;
  localparam int FRAC_BITS     = 14;
  localparam int CORDIC_STAGES = 14;
  localparam int ATAN_COUNT    = 24;
  localparam int NUM_ROT       = (CORDIC_STAGES > ATAN_COUNT) ? ATAN_COUNT : CORDIC_STAGES;

  localparam int WORK_BITS   = FRAC_BITS + 2;
  localparam int ROUND_SHIFT = WORK_BITS - FRAC_BITS;
  localparam int CORD_W      = WORK_BITS + 2;
  localparam int TURN_SHIFT  = 31 - ANGLE_W;
  localparam int ZW          = 33;
  localparam int TRIG_W      = FRAC_BITS + 2;
  localparam int PROD_W      = 2 * TRIG_W;
  localparam int SUM_W       = PROD_W + 1;

  localparam int NUM_LANES  = 3;
  localparam int LANE_HEAD  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_BANK  = 2;

  localparam longint GAIN_Q32   = 64'd2608131496;
  localparam int     GAIN_SHIFT = 32 - WORK_BITS;
  localparam longint X0 = (GAIN_SHIFT == 0) ? GAIN_Q32 :
                          ((GAIN_Q32 + (longint'(1) << (GAIN_SHIFT - 1))) >> GAIN_SHIFT);
  localparam logic signed [CORD_W-1:0] X0_C = CORD_W'(X0);

  localparam logic [31:0] ATAN_TURNS [ATAN_COUNT] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [QUAT_W-1:0]  quat_t;
  typedef logic signed [TRIG_W-1:0]  trig_t;

endpackage

FILE: src/eaq_if.sv
// ----------------------------------------------------------------------------
// Euler angles to quaternion: channel interfaces
// Valid/ready channels for the angle words and the quaternion words.
// ----------------------------------------------------------------------------
interface eaq_in_if import eaq_pkg::*; ();
  logic   valid;
  logic   ready;
  angle_t heading_angle;
  angle_t pitch_angle;
  angle_t bank_angle;
  logic   inverse;

  modport source (output valid, output heading_angle, output pitch_angle,
                  output bank_angle, output inverse, input ready);
  modport sink   (input valid, input heading_angle, input pitch_angle,
                  input bank_angle, input inverse, output ready);
endinterface

interface eaq_out_if import eaq_pkg::*; ();
  logic  valid;
  logic  ready;
  quat_t quat_w;
  quat_t quat_x;
  quat_t quat_y;
  quat_t quat_z;

  modport source (output valid, output quat_w, output quat_x, output quat_y,
                  output quat_z, input ready);
  modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                  input quat_z, output ready);
endinterface

FILE: src/euler_angles_to_quaternion.sv
// ----------------------------------------------------------------------------
// Euler angles to quaternion
// Pipelined CORDIC sine/cosine of the half angles, then pair and triple
// products that form the rotation quaternion or its conjugate.
// ----------------------------------------------------------------------------
//  channel  modport  word
//  in_i     sink     heading_angle, pitch_angle, bank_angle, inverse
//  out_o    source   quat_w, quat_x, quat_y, quat_z
//
//  One word is accepted per cycle while the output is taken or a stage has a
//  hole; a word passes one register per CORDIC rotation (14 rotations) plus
//  input, rounding, two product and output stages.
//  Reset clears only the stage valid bits.
//  A stage advances whenever it or a later stage has a hole or the output is taken,
//  so empty stages fill while a finished word waits.
// ----------------------------------------------------------------------------
module euler_angles_to_quaternion import eaq_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  eaq_in_if.sink    in_i,
  eaq_out_if.source out_o
);

  localparam int ST_SC  = NUM_ROT + 1;
  localparam int ST_PP  = NUM_ROT + 2;
  localparam int ST_TP  = NUM_ROT + 3;
  localparam int ST_OUT = NUM_ROT + 4;
  localparam int NS     = NUM_ROT + 5;

  localparam int ONE     = 1 << FRAC_BITS;
  localparam int HALF_RS = 1 << (ROUND_SHIFT - 1);
  localparam int HALF_F  = 1 << (FRAC_BITS - 1);

  function automatic trig_t rnd_cord(input logic signed [CORD_W-1:0] v);
    logic signed [CORD_W-1:0] r;
    r = (v + CORD_W'(HALF_RS)) >>> ROUND_SHIFT;
    if (r > CORD_W'(ONE)) begin
      return TRIG_W'(ONE);
    end else if (r < -CORD_W'(ONE)) begin
      return -TRIG_W'(ONE);
    end
    return TRIG_W'(r);
  endfunction

  function automatic trig_t rnd_pair(input trig_t a, input trig_t b);
    logic signed [PROD_W-1:0] p;
    p = a * b;
    p = (p + PROD_W'(HALF_F)) >>> FRAC_BITS;
    return p[TRIG_W-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] dot2(input trig_t a, input trig_t b,
                                                   input trig_t c, input trig_t d,
                                                   input logic  sub);
    logic signed [PROD_W-1:0] m1;
    logic signed [PROD_W-1:0] m2;
    m1 = a * b;
    m2 = c * d;
    if (sub) begin
      return SUM_W'(m1) - SUM_W'(m2);
    end
    return SUM_W'(m1) + SUM_W'(m2);
  endfunction

  function automatic trig_t finish(input logic signed [SUM_W-1:0] t);
    logic signed [SUM_W-1:0] r;
    r = (t + SUM_W'(HALF_F)) >>> FRAC_BITS;
    if (r > SUM_W'(ONE)) begin
      return TRIG_W'(ONE);
    end else if (r < -SUM_W'(ONE)) begin
      return -TRIG_W'(ONE);
    end
    return TRIG_W'(r);
  endfunction

  logic [NS-1:0]    v_q;
  logic [NS-1:0]    en;
  logic [ST_TP:0]   inv_q;

  angle_t                   ang_q [NUM_LANES];
  logic signed [CORD_W-1:0] x_q   [NUM_ROT][NUM_LANES];
  logic signed [CORD_W-1:0] y_q   [NUM_ROT][NUM_LANES];
  logic signed [ZW-1:0]     z_q   [NUM_ROT][NUM_LANES];
  trig_t                    sin_q [NUM_LANES];
  trig_t                    cos_q [NUM_LANES];
  trig_t                    sh_q, ch_q, cpcb_q, spsb_q, spcb_q, cpsb_q;
  logic signed [SUM_W-1:0]  tw_q, tx_q, ty_q, tz_q;
  trig_t                    qw_q, qx_q, qy_q, qz_q;

  for (genvar s = 0; s < NS; s++) begin : g_en
    assign en[s] = out_o.ready || !(&v_q[NS-1:s]);
  end

  assign in_i.ready   = en[0];
  assign out_o.valid  = v_q[ST_OUT];
  assign out_o.quat_w = QUAT_W'(qw_q);
  assign out_o.quat_x = QUAT_W'(qx_q);
  assign out_o.quat_y = QUAT_W'(qy_q);
  assign out_o.quat_z = QUAT_W'(qz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int s = 1; s < NS; s++) begin
        if (en[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      inv_q[0]              <= in_i.inverse;
      ang_q[LANE_HEAD]      <= in_i.heading_angle;
      ang_q[LANE_PITCH]     <= in_i.pitch_angle;
      ang_q[LANE_BANK]      <= in_i.bank_angle;
    end
    for (int s = 1; s <= ST_TP; s++) begin
      if (en[s]) begin
        inv_q[s] <= inv_q[s-1];
      end
    end
  end

  for (genvar k = 0; k < NUM_ROT; k++) begin : g_rot
    logic signed [CORD_W-1:0] xi [NUM_LANES];
    logic signed [CORD_W-1:0] yi [NUM_LANES];
    logic signed [ZW-1:0]     zi [NUM_LANES];

    if (k == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
          xi[l] = X0_C;
          yi[l] = '0;
          zi[l] = ZW'($signed({ang_q[l], {TURN_SHIFT{1'b0}}}));
        end
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
          xi[l] = x_q[k-1][l];
          yi[l] = y_q[k-1][l];
          zi[l] = z_q[k-1][l];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k+1]) begin
        for (int l = 0; l < NUM_LANES; l++) begin
          if (!zi[l][ZW-1]) begin
            x_q[k][l] <= xi[l] - (yi[l] >>> k);
            y_q[k][l] <= yi[l] + (xi[l] >>> k);
            z_q[k][l] <= zi[l] - $signed(ZW'(ATAN_TURNS[k]));
          end else begin
            x_q[k][l] <= xi[l] + (yi[l] >>> k);
            y_q[k][l] <= yi[l] - (xi[l] >>> k);
            z_q[k][l] <= zi[l] + $signed(ZW'(ATAN_TURNS[k]));
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_SC]) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        cos_q[l] <= rnd_cord(x_q[NUM_ROT-1][l]);
        sin_q[l] <= rnd_cord(y_q[NUM_ROT-1][l]);
      end
    end
    if (en[ST_PP]) begin
      sh_q   <= sin_q[LANE_HEAD];
      ch_q   <= cos_q[LANE_HEAD];
      cpcb_q <= rnd_pair(cos_q[LANE_PITCH], cos_q[LANE_BANK]);
      spsb_q <= rnd_pair(sin_q[LANE_PITCH], sin_q[LANE_BANK]);
      spcb_q <= rnd_pair(sin_q[LANE_PITCH], cos_q[LANE_BANK]);
      cpsb_q <= rnd_pair(cos_q[LANE_PITCH], sin_q[LANE_BANK]);
    end
    if (en[ST_TP]) begin
      tw_q <= dot2(ch_q, cpcb_q, sh_q, spsb_q, 1'b0);
      tx_q <= dot2(ch_q, spcb_q, sh_q, cpsb_q, 1'b0);
      ty_q <= dot2(sh_q, cpcb_q, ch_q, spsb_q, 1'b1);
      tz_q <= dot2(ch_q, cpsb_q, sh_q, spcb_q, 1'b1);
    end
    if (en[ST_OUT]) begin
      qw_q <= finish(tw_q);
      qx_q <= inv_q[ST_TP] ? -finish(tx_q) : finish(tx_q);
      qy_q <= inv_q[ST_TP] ? -finish(ty_q) : finish(ty_q);
      qz_q <= inv_q[ST_TP] ? -finish(tz_q) : finish(tz_q);
    end
  end

  // The input side stalls only when every stage holds a word.
  a_full_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> &v_q)
    else $error("input stalled while the pipeline has a hole");

  a_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && en[1] |=> v_q[1])
    else $error("a word was lost between the input and first rotation stage");

  a_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en[0] && !in_i.valid |=> !v_q[0])
    else $error("a word appeared without an input handshake");

  a_w_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_OUT] |-> (qw_q <= TRIG_W'(ONE)) && (qw_q >= -TRIG_W'(ONE)))
    else $error("scalar part outside the unit range");

endmodule
